FILE: hdl/fpoc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpoc_pkg: shared types and constants of the operand unpack core
// Operation and class codes, exponent biases, the request and result
// structs, and the internal stage structs.
// ---------------------------------------------------------------------------
package fpoc_pkg;

  // Operation codes.
  localparam logic [2:0] OP_INT32 = 3'd0;
  localparam logic [2:0] OP_INT64 = 3'd1;
  localparam logic [2:0] OP_SGL   = 3'd2;
  localparam logic [2:0] OP_DBL   = 3'd3;
  localparam logic [2:0] OP_EXT   = 3'd4;

  // Operand classes.
  localparam logic [2:0] CLS_ZERO   = 3'd0;
  localparam logic [2:0] CLS_NORMAL = 3'd1;
  localparam logic [2:0] CLS_INF    = 3'd2;
  localparam logic [2:0] CLS_QNAN   = 3'd3;
  localparam logic [2:0] CLS_SNAN   = 3'd4;

  // Exponent constants.
  localparam logic [15:0] EXP_INT32    = 16'd31;
  localparam logic [15:0] EXP_INT64    = 16'd63;
  localparam logic [15:0] BIAS_SGL     = 16'd127;
  localparam logic [15:0] BIAS_DBL     = 16'd1023;
  localparam logic [15:0] BIAS_EXT     = 16'd16383;
  localparam logic [15:0] EXP_SGL_SUB  = 16'(-133);
  localparam logic [15:0] EXP_DBL_SUB  = 16'(-1026);
  localparam logic [15:0] EXP_EXT_SUB  = 16'(-16382);
  localparam logic [15:0] EXP_EXT_ZERO = 16'(-16383);
  localparam logic [15:0] EXP_EXT_MAX  = 16'd16384;

  // The aligned significand is 128 bits wide; the final leading one sits
  // at bit 127 before the top 113 bits are taken.
  localparam int SIG_W   = 113;
  localparam int ALIGN_W = 128;
  localparam logic [15:0] ALIGN_PAD = 16'(ALIGN_W - SIG_W);

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
  } fpoc_req_t;

  typedef struct packed {
    logic               sign_bit;
    logic [2:0]         operand_class;
    logic signed [15:0] unbiased_exponent;
    logic [16:0]        sig_top;
    logic [31:0]        sig_second;
    logic [31:0]        sig_third;
    logic [31:0]        sig_fourth;
    logic               invalid_flag;
  } fpoc_rsp_t;

  // Unpacked operand before normalization.
  typedef struct packed {
    logic                 sign;
    logic [2:0]           cls;
    logic                 inv;
    logic [15:0]          exp0;
    logic [ALIGN_W-1:0]   sig;
  } fpoc_unp_t;

  // Leading-zero information per 32-bit word, word 3 is the most significant.
  typedef struct packed {
    logic [3:0]      nz;
    logic [3:0][4:0] lz;
  } fpoc_lzc_t;

endpackage

FILE: hdl/fpoc_unpack.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpoc_unpack: operand field extraction and classification
// Splits the packed operand into sign, class and starting exponent, and
// places its significand in a 128-bit word ready for normalization.
// ---------------------------------------------------------------------------
module fpoc_unpack import fpoc_pkg::*; (
  input  fpoc_req_t req,
  output fpoc_unp_t unp
);

  logic [31:0] mag32;
  logic [63:0] mag64;
  logic [7:0]  exs;
  logic [22:0] us;
  logic [10:0] exd;
  logic [19:0] ud;
  logic [14:0] exe;
  logic [15:0] ue;
  logic        ext_frac_nz;

  always_comb begin
    mag32 = req.word0[31] ? (~req.word0 + 32'd1) : req.word0;
    mag64 = req.word0[31] ? (~{req.word0, req.word1} + 64'd1) : {req.word0, req.word1};
    exs = req.word0[30:23];
    us  = req.word0[22:0];
    exd = req.word0[30:20];
    ud  = req.word0[19:0];
    exe = req.word0[30:16];
    ue  = req.word0[15:0];
    ext_frac_nz = |{ue, req.word1, req.word2, req.word3};

    unp.sign = 1'b0;
    unp.cls  = CLS_ZERO;
    unp.inv  = 1'b0;
    unp.exp0 = 16'd0;
    unp.sig  = '0;

    case (req.operation)
      OP_INT32: begin
        if (req.word0 != 32'd0) begin
          unp.sign = req.word0[31];
          unp.cls  = CLS_NORMAL;
          unp.exp0 = EXP_INT32;
          unp.sig  = {15'd0, mag32, 81'd0};
        end
      end
      OP_INT64: begin
        if ({req.word0, req.word1} != 64'd0) begin
          unp.sign = req.word0[31];
          unp.cls  = CLS_NORMAL;
          unp.exp0 = EXP_INT64;
          unp.sig  = {15'd0, mag64, 49'd0};
        end
      end
      OP_SGL: begin
        unp.sign = req.word0[31];
        if (exs == 8'd0) begin
          if (us != 23'd0) begin
            unp.cls  = CLS_NORMAL;
            unp.exp0 = EXP_SGL_SUB;
            unp.sig  = {9'd0, us, 96'd0};
          end
        end else if (exs == 8'hff) begin
          if (us == 23'd0) begin
            unp.cls = CLS_INF;
          end else begin
            unp.cls = us[22] ? CLS_QNAN : CLS_SNAN;
            unp.inv = ~us[22];
            unp.sig = {15'd0, 2'b11, us[21:0], 89'd0};
          end
        end else begin
          unp.cls  = CLS_NORMAL;
          unp.exp0 = {8'd0, exs} - BIAS_SGL;
          unp.sig  = {15'd0, 1'b1, us, 89'd0};
        end
      end
      OP_DBL: begin
        unp.sign = req.word0[31];
        if (exd == 11'd0) begin
          if ((ud != 20'd0) || (req.word1 != 32'd0)) begin
            unp.cls  = CLS_NORMAL;
            unp.exp0 = EXP_DBL_SUB;
            unp.sig  = {12'd0, ud, req.word1, 64'd0};
          end
        end else if (exd == 11'h7ff) begin
          if ((ud == 20'd0) && (req.word1 == 32'd0)) begin
            unp.cls = CLS_INF;
          end else begin
            unp.cls = ud[19] ? CLS_QNAN : CLS_SNAN;
            unp.inv = ~ud[19];
            unp.sig = {15'd0, 2'b11, ud[18:0], req.word1, 60'd0};
          end
        end else begin
          unp.cls  = CLS_NORMAL;
          unp.exp0 = {5'd0, exd} - BIAS_DBL;
          unp.sig  = {15'd0, 1'b1, ud, req.word1, 60'd0};
        end
      end
      OP_EXT: begin
        unp.sign = req.word0[31];
        if (exe == 15'd0) begin
          if (ext_frac_nz) begin
            // Subnormal: the implicit bit is zero and the exponent is one
            // above the biased-zero value.
            unp.cls  = CLS_NORMAL;
            unp.exp0 = EXP_EXT_SUB;
            unp.sig  = {16'd0, ue, req.word1, req.word2, req.word3};
          end else begin
            unp.exp0 = EXP_EXT_ZERO;
          end
        end else if (exe == 15'h7fff) begin
          unp.exp0 = EXP_EXT_MAX;
          if (!ext_frac_nz) begin
            unp.cls = CLS_INF;
            unp.sig = {15'd0, 1'b1, 112'd0};
          end else begin
            unp.cls = ue[15] ? CLS_QNAN : CLS_SNAN;
            unp.inv = ~ue[15];
            unp.sig = {15'd0, 2'b11, ue[14:0], req.word1, req.word2, req.word3};
          end
        end else begin
          unp.cls  = CLS_NORMAL;
          unp.exp0 = {1'b0, exe} - BIAS_EXT;
          unp.sig  = {15'd0, 1'b1, ue, req.word1, req.word2, req.word3};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/fpoc_lzc.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpoc_lzc: per-word leading-zero count
// Counts leading zeros in each 32-bit word of the aligned significand and
// flags the words that are nonzero.
// ---------------------------------------------------------------------------
module fpoc_lzc import fpoc_pkg::*; (
  input  logic [ALIGN_W-1:0] sig,
  output fpoc_lzc_t          lzc
);

  function automatic logic [4:0] lz32(input logic [31:0] w);
    logic [4:0] cnt;
    cnt = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (w[i]) begin
        cnt = 5'(31 - i);
      end
    end
    return cnt;
  endfunction

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lzc.nz[k] = |sig[k*32 +: 32];
      lzc.lz[k] = lz32(sig[k*32 +: 32]);
    end
  end

endmodule

FILE: hdl/fpoc_norm.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpoc_norm: significand normalization and result packing
// Combines the per-word counts into one shift, moves the leading one to
// the top, and adjusts the exponent by the same amount.
// ---------------------------------------------------------------------------
module fpoc_norm import fpoc_pkg::*; (
  input  fpoc_unp_t unp,
  input  fpoc_lzc_t lzc,
  output fpoc_rsp_t rsp
);

  logic [6:0]         shamt;
  logic [ALIGN_W-1:0] shifted;
  logic [15:0]        exp_adj;

  always_comb begin
    if (lzc.nz[3]) begin
      shamt = {2'd0, lzc.lz[3]};
    end else if (lzc.nz[2]) begin
      shamt = {2'd1, lzc.lz[2]};
    end else if (lzc.nz[1]) begin
      shamt = {2'd2, lzc.lz[1]};
    end else begin
      shamt = {2'd3, lzc.lz[0]};
    end

    shifted = unp.sig << shamt;

    // A zero significand keeps its starting exponent.
    if (|lzc.nz) begin
      exp_adj = unp.exp0 + ALIGN_PAD - {9'd0, shamt};
    end else begin
      exp_adj = unp.exp0;
    end

    rsp.sign_bit          = unp.sign;
    rsp.operand_class     = unp.cls;
    rsp.unbiased_exponent = $signed(exp_adj);
    rsp.sig_top           = shifted[127:111];
    rsp.sig_second        = shifted[110:79];
    rsp.sig_third         = shifted[78:47];
    rsp.sig_fourth        = shifted[46:15];
    rsp.invalid_flag      = unp.inv;
  end

endmodule

FILE: hdl/fp_operand_unpack_classify_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fp_operand_unpack_classify_core: FPU operand unpack and classify
// Unpacks an int32, int64, single, double or 128-bit extended operand into
// sign, class, unbiased exponent and a normalized 113-bit significand.
//
//   channel   direction  handshake                       payload
//   operand   in         operand_valid / operand_stall   fpoc_req_t
//   result    out        result_valid  / result_stall    fpoc_rsp_t
//
// One request is accepted every cycle while operand_stall is low. The
// accepting edge loads the input register, and the result is presented
// after the unpack, leading-zero count and normalize registers have each
// held it. Reset clears only the stage valid bits.
// A stall on the result side freezes full stages; empty stages keep
// filling, so requests are taken until the whole pipeline is occupied.
// ---------------------------------------------------------------------------
module fp_operand_unpack_classify_core import fpoc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      operand_valid,
  output logic      operand_stall,
  input  fpoc_req_t operand,
  output logic      result_valid,
  input  logic      result_stall,
  output fpoc_rsp_t result
);

  logic      v1, v2, v3, v4;
  logic      en1, en2, en3, en4;
  fpoc_req_t req_q;
  fpoc_unp_t unp_d, unp_q, unp2_q;
  fpoc_lzc_t lzc_d, lzc_q;
  fpoc_rsp_t rsp_d, rsp_q;

  assign en4 = ~v4 | ~result_stall;
  assign en3 = ~v3 | en4;
  assign en2 = ~v2 | en3;
  assign en1 = ~v1 | en2;

  assign operand_stall = ~en1;
  assign result_valid  = v4;
  assign result        = rsp_q;

  fpoc_unpack u_unpack (
    .req (req_q),
    .unp (unp_d)
  );

  fpoc_lzc u_lzc (
    .sig (unp_q.sig),
    .lzc (lzc_d)
  );

  fpoc_norm u_norm (
    .unp (unp2_q),
    .lzc (lzc_q),
    .rsp (rsp_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= operand_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && operand_valid) begin
      req_q <= operand;
    end
    if (en2 && v1) begin
      unp_q <= unp_d;
    end
    if (en3 && v2) begin
      unp2_q <= unp_q;
      lzc_q  <= lzc_d;
    end
    if (en4 && v3) begin
      rsp_q <= rsp_d;
    end
  end

endmodule
